[src/timed_priority_task_dispatcher_defines.svh]
// assertion macros for the task dispatcher
`ifndef TIMED_PRIORITY_TASK_DISPATCHER_DEFINES_SVH
`define TIMED_PRIORITY_TASK_DISPATCHER_DEFINES_SVH
// property that holds on every clock edge outside reset
`define TPD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// property that holds on every clock edge, reset included
`define TPD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);
`endif

[src/tptd_pkg.sv]
// shared types and constants for the task dispatcher
package tptd_pkg;

    localparam logic [2:0] OP_SUBMIT_NOW = 3'd0;
    localparam logic [2:0] OP_SUBMIT_AT  = 3'd1;
    localparam logic [2:0] OP_BARRIER    = 3'd2;
    localparam logic [2:0] OP_STEP       = 3'd3;
    localparam logic [2:0] OP_ADVANCE    = 3'd4;
    localparam logic [2:0] OP_QUERY      = 3'd5;

    localparam logic [2:0] K_ACCEPTED   = 3'd0;
    localparam logic [2:0] K_DISPATCHED = 3'd1;
    localparam logic [2:0] K_STEP_DONE  = 3'd2;
    localparam logic [2:0] K_ACK        = 3'd3;
    localparam logic [2:0] K_BARRIER    = 3'd4;
    localparam logic [2:0] K_REJECTED   = 3'd5;

    localparam logic CFG_FUZZ_ENABLE = 1'b0;
    localparam logic CFG_FUZZ_SEED   = 1'b1;

    localparam int HASH_SH_A = 13;
    localparam int HASH_SH_B = 7;
    localparam int HASH_SH_C = 17;

    typedef struct packed {
        logic [2:0]  operation;
        logic [63:0] tick_value;
        logic [7:0]  priority_req;
        logic [31:0] barrier_id;
    } t_request;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] task_id;
        logic [63:0] tick_out;
        logic [7:0]  priority_out;
        logic        barrier_reached;
        logic [5:0]  pending_count;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [63:0] tick;
        logic [7:0]  prio;
        logic [63:0] arrival;
        logic [31:0] task_id;
    } t_slot;

    // scan engine states
    typedef enum logic [2:0] {
        S_IDLE,
        S_BAR_SCAN,
        S_TASK_SCAN,
        S_TASK_LAST,
        S_EMIT,
        S_FINISH
    } t_state;

    function automatic logic [63:0] tie_hash(input logic [63:0] arr, input logic [63:0] seed);
        logic [63:0] x;
        x = arr ^ seed;
        x = x ^ (x << HASH_SH_A);
        x = x ^ (x >> HASH_SH_B);
        x = x ^ (x << HASH_SH_C);
        return x;
    endfunction

endpackage

[src/tptd_order.sv]
// ordering key compare: is candidate ahead of the current best
module tptd_order (
    input  tptd_pkg::t_slot i_cand,
    input  logic [63:0]     i_cand_hash,
    input  tptd_pkg::t_slot i_best,
    input  logic [63:0]     i_best_hash,
    input  logic            i_fuzz,
    output logic            o_first
);
    always_comb begin
        if (i_cand.tick != i_best.tick) begin
            o_first = i_cand.tick < i_best.tick;
        end else if (i_cand.prio != i_best.prio) begin
            o_first = i_cand.prio < i_best.prio;
        end else if (i_fuzz && (i_cand_hash != i_best_hash)) begin
            o_first = i_cand_hash < i_best_hash;
        end else begin
            o_first = i_cand.arrival < i_best.arrival;
        end
    end
endmodule

[src/timed_priority_task_dispatcher.sv]
// timed priority task dispatcher: top level with slot and barrier memories
// Requests are taken when i_start is high and o_busy is low; every result is shown
// for one cycle with o_valid and must be taken at once. Submit, barrier add, advance
// and query never raise busy and give one result in the cycle right after the
// accepting edge, so they can follow each other back to back. A step first reads
// the barrier memory, one entry a cycle, then for each due task walks the slot
// memory once, one slot a cycle, plus one final walk that finds nothing, and ends
// with a finish state; a step holds busy throughout. The slot memory read port
// sets this pace. No clearing pass is needed: valid bits live in flip-flops,
// payload in memory.
module timed_priority_task_dispatcher #(
    parameter int QUEUE_DEPTH   = 32,
    parameter int BARRIER_DEPTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  tptd_pkg::t_request   i_req,
    output logic                 o_busy,
    output logic                 o_valid,
    output tptd_pkg::t_result    o_result,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic                 i_cfg_index,
    input  logic [63:0]          i_cfg_data
);
    `include "timed_priority_task_dispatcher_defines.svh"

    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int BW = (BARRIER_DEPTH > 1) ? $clog2(BARRIER_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    // scan position must reach both table depths
    localparam int IW = (QUEUE_DEPTH > BARRIER_DEPTH) ? $clog2(QUEUE_DEPTH + 1)
                                                      : $clog2(BARRIER_DEPTH + 1);

    // configuration
    logic        r_fuzz;
    logic [63:0] r_seed;
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fuzz <= 1'b0;
            r_seed <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tptd_pkg::CFG_FUZZ_ENABLE: r_fuzz <= i_cfg_data[0];
                tptd_pkg::CFG_FUZZ_SEED:   r_seed <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // memories: slot payload and barrier ticks, registered read
    tptd_pkg::t_slot r_slot_mem [QUEUE_DEPTH];
    logic [63:0]     r_bar_mem  [BARRIER_DEPTH];
    logic            slot_we;
    logic [QW-1:0]   slot_waddr;
    tptd_pkg::t_slot slot_wdata;
    logic [QW-1:0]   slot_raddr;
    tptd_pkg::t_slot r_slot_rd;
    logic            bar_we;
    logic [BW-1:0]   bar_waddr;
    logic [BW-1:0]   bar_raddr;
    logic [63:0]     r_bar_rd;

    always_ff @(posedge i_clk) begin
        if (slot_we) r_slot_mem[slot_waddr] <= slot_wdata;
        r_slot_rd <= r_slot_mem[slot_raddr];
    end
    always_ff @(posedge i_clk) begin
        if (bar_we) r_bar_mem[bar_waddr] <= i_req.tick_value;
        r_bar_rd <= r_bar_mem[bar_raddr];
    end

    // control state
    tptd_pkg::t_state r_state, n_state;
    logic [QUEUE_DEPTH-1:0]   r_svalid, n_svalid;
    logic [BARRIER_DEPTH-1:0] r_bvalid, n_bvalid;
    logic [BARRIER_DEPTH-1:0] r_bdone, n_bdone;
    logic [63:0]  r_tick, n_tick;
    logic [31:0]  r_task_num, n_task_num;
    logic [63:0]  r_arrival, n_arrival;
    logic [31:0]  r_bar_num, n_bar_num;
    logic [CW-1:0] r_pending, n_pending;
    logic [IW-1:0] r_idx, n_idx;          // scan position (slot or barrier)
    logic [QW-1:0] r_rd_idx, n_rd_idx;    // slot index of data in r_slot_rd
    logic         r_rd_live, n_rd_live;   // r_slot_rd holds a scanned entry
    logic [BW-1:0] r_bar_rd_idx, n_bar_rd_idx;
    logic         r_bar_live, n_bar_live;
    logic         r_have_best, n_have_best;
    logic [QW-1:0] r_best_idx, n_best_idx;
    tptd_pkg::t_slot r_best, n_best;
    logic [63:0]  r_best_hash, n_best_hash;
    logic         r_out_valid, n_out_valid;
    tptd_pkg::t_result r_out, n_out;

    // free slot search
    logic          free_found;
    logic [QW-1:0] free_idx;
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
            if (!r_svalid[i]) begin
                free_found = 1'b1;
                free_idx   = QW'(i);
            end
        end
    end

    logic accept;
    assign accept = i_start && !o_busy;
    assign o_busy = (r_state != tptd_pkg::S_IDLE);

    // candidate compare on the slot read data
    logic [63:0] cand_hash;
    logic        cand_first;
    logic        cand_ok;
    assign cand_hash = tptd_pkg::tie_hash(r_slot_rd.arrival, r_seed);
    tptd_order u_order (
        .i_cand      (r_slot_rd),
        .i_cand_hash (cand_hash),
        .i_best      (r_best),
        .i_best_hash (r_best_hash),
        .i_fuzz      (r_fuzz),
        .o_first     (cand_first)
    );
    assign cand_ok = r_rd_live && r_svalid[r_rd_idx] && (r_slot_rd.tick <= r_tick);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tptd_pkg::S_IDLE: begin
                if (accept && i_req.operation == tptd_pkg::OP_STEP)
                    n_state = tptd_pkg::S_BAR_SCAN;
            end
            tptd_pkg::S_BAR_SCAN: begin
                if (r_idx == IW'(BARRIER_DEPTH)) n_state = tptd_pkg::S_TASK_SCAN;
            end
            tptd_pkg::S_TASK_SCAN: begin
                if (r_idx == IW'(QUEUE_DEPTH - 1)) n_state = tptd_pkg::S_TASK_LAST;
            end
            tptd_pkg::S_TASK_LAST: begin
                n_state = tptd_pkg::S_EMIT;
            end
            tptd_pkg::S_EMIT: begin
                n_state = r_have_best ? tptd_pkg::S_TASK_SCAN : tptd_pkg::S_FINISH;
            end
            tptd_pkg::S_FINISH: n_state = tptd_pkg::S_IDLE;
            default: n_state = tptd_pkg::S_IDLE;
        endcase
    end

    // memory addresses and writes
    always_comb begin
        slot_raddr = r_idx[QW-1:0];
        bar_raddr  = BW'(r_idx);
        slot_we    = accept && (i_req.operation == tptd_pkg::OP_SUBMIT_NOW ||
                                i_req.operation == tptd_pkg::OP_SUBMIT_AT) && free_found;
        slot_waddr = free_idx;
        slot_wdata.tick    = (i_req.operation == tptd_pkg::OP_SUBMIT_NOW) ? r_tick
                                                                          : i_req.tick_value;
        slot_wdata.prio    = i_req.priority_req;
        slot_wdata.arrival = r_arrival;
        slot_wdata.task_id = r_task_num;
        bar_we    = accept && i_req.operation == tptd_pkg::OP_BARRIER &&
                    r_bar_num >= 32'd1 && r_bar_num <= 32'(BARRIER_DEPTH);
        bar_waddr = BW'(r_bar_num - 32'd1);
    end

    // next values of the control and result registers
    always_comb begin
        n_svalid     = r_svalid;
        n_bvalid     = r_bvalid;
        n_bdone      = r_bdone;
        n_tick       = r_tick;
        n_task_num   = r_task_num;
        n_arrival    = r_arrival;
        n_bar_num    = r_bar_num;
        n_pending    = r_pending;
        n_idx        = r_idx;
        n_rd_idx     = r_idx[QW-1:0];
        n_bar_rd_idx = BW'(r_idx);
        n_rd_live    = 1'b0;
        n_bar_live   = 1'b0;
        n_have_best  = r_have_best;
        n_best_idx   = r_best_idx;
        n_best       = r_best;
        n_best_hash  = r_best_hash;
        n_out_valid  = 1'b0;
        n_out        = r_out;
        case (r_state)
            tptd_pkg::S_IDLE: begin
                n_idx       = '0;
                n_have_best = 1'b0;
                if (accept) begin
                    n_out_valid         = 1'b1;
                    n_out               = '0;
                    n_out.last          = 1'b1;
                    n_out.pending_count = 6'(r_pending);
                    case (i_req.operation)
                        tptd_pkg::OP_SUBMIT_NOW, tptd_pkg::OP_SUBMIT_AT: begin
                            n_out.tick_out     = slot_wdata.tick;
                            n_out.priority_out = i_req.priority_req;
                            if (free_found) begin
                                n_svalid[free_idx]  = 1'b1;
                                n_pending           = r_pending + CW'(1);
                                n_out.pending_count = 6'(r_pending + CW'(1));
                                n_arrival           = r_arrival + 64'd1;
                                n_task_num          = r_task_num + 32'd1;
                                n_out.kind          = tptd_pkg::K_ACCEPTED;
                                n_out.task_id       = r_task_num;
                            end else begin
                                n_out.kind = tptd_pkg::K_REJECTED;
                            end
                        end
                        tptd_pkg::OP_BARRIER: begin
                            n_out.tick_out = i_req.tick_value;
                            if (bar_we) begin
                                n_bvalid[bar_waddr] = 1'b1;
                                n_bdone[bar_waddr]  = 1'b0;
                                n_bar_num           = r_bar_num + 32'd1;
                                n_out.kind          = tptd_pkg::K_ACK;
                                n_out.task_id       = r_bar_num;
                            end else begin
                                n_out.kind = tptd_pkg::K_REJECTED;
                            end
                        end
                        tptd_pkg::OP_STEP: begin
                            // entry 0 is read at this edge, the scan starts at 1
                            n_out_valid = 1'b0;
                            n_idx       = IW'(1);
                            n_bar_live  = 1'b1;
                        end
                        tptd_pkg::OP_ADVANCE: begin
                            n_tick         = r_tick + i_req.tick_value;
                            n_out.kind     = tptd_pkg::K_ACK;
                            n_out.tick_out = r_tick + i_req.tick_value;
                        end
                        tptd_pkg::OP_QUERY: begin
                            n_out.kind     = tptd_pkg::K_BARRIER;
                            n_out.task_id  = i_req.barrier_id;
                            n_out.tick_out = r_tick;
                            if (i_req.barrier_id >= 32'd1 &&
                                i_req.barrier_id <= 32'(BARRIER_DEPTH))
                                n_out.barrier_reached =
                                    r_bdone[BW'(i_req.barrier_id - 32'd1)] &&
                                    r_bvalid[BW'(i_req.barrier_id - 32'd1)];
                        end
                        default: n_out.kind = tptd_pkg::K_ACK;
                    endcase
                end
            end
            tptd_pkg::S_BAR_SCAN: begin
                // r_bar_rd holds entry r_bar_rd_idx from last cycle
                if (r_bar_live && r_bvalid[r_bar_rd_idx] && r_bar_rd == r_tick)
                    n_bdone[r_bar_rd_idx] = 1'b1;
                if (r_idx == IW'(BARRIER_DEPTH)) begin
                    n_idx = '0;
                end else begin
                    n_idx      = r_idx + IW'(1);
                    n_bar_live = 1'b1;
                end
            end
            tptd_pkg::S_TASK_SCAN, tptd_pkg::S_TASK_LAST: begin
                if (r_state == tptd_pkg::S_TASK_SCAN) begin
                    n_idx     = r_idx + IW'(1);
                    n_rd_live = 1'b1;
                end
                if (cand_ok && (!r_have_best || cand_first)) begin
                    n_have_best = 1'b1;
                    n_best      = r_slot_rd;
                    n_best_hash = cand_hash;
                    n_best_idx  = r_rd_idx;
                end
            end
            tptd_pkg::S_EMIT: begin
                n_idx       = '0;
                n_have_best = 1'b0;
                if (r_have_best) begin
                    n_svalid[r_best_idx] = 1'b0;
                    n_pending            = r_pending - CW'(1);
                    n_out_valid          = 1'b1;
                    n_out                = '0;
                    n_out.kind           = tptd_pkg::K_DISPATCHED;
                    n_out.task_id        = r_best.task_id;
                    n_out.tick_out       = r_best.tick;
                    n_out.priority_out   = r_best.prio;
                    n_out.pending_count  = 6'(r_pending - CW'(1));
                end
            end
            tptd_pkg::S_FINISH: begin
                n_tick              = r_tick + 64'd1;
                n_out_valid         = 1'b1;
                n_out               = '0;
                n_out.kind          = tptd_pkg::K_STEP_DONE;
                n_out.tick_out      = r_tick + 64'd1;
                n_out.pending_count = 6'(r_pending);
                n_out.last          = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tptd_pkg::S_IDLE;
            r_svalid    <= '0;
            r_bvalid    <= '0;
            r_bdone     <= '0;
            r_tick      <= '0;
            r_task_num  <= 32'd1;
            r_arrival   <= '0;
            r_bar_num   <= 32'd1;
            r_pending   <= '0;
            r_idx       <= '0;
            r_rd_live   <= 1'b0;
            r_bar_live  <= 1'b0;
            r_have_best <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_svalid    <= n_svalid;
            r_bvalid    <= n_bvalid;
            r_bdone     <= n_bdone;
            r_tick      <= n_tick;
            r_task_num  <= n_task_num;
            r_arrival   <= n_arrival;
            r_bar_num   <= n_bar_num;
            r_pending   <= n_pending;
            r_idx       <= n_idx;
            r_rd_live   <= n_rd_live;
            r_bar_live  <= n_bar_live;
            r_have_best <= n_have_best;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath registers, qualified by the live and valid flags above
    always_ff @(posedge i_clk) begin
        r_rd_idx     <= n_rd_idx;
        r_bar_rd_idx <= n_bar_rd_idx;
        r_best_idx   <= n_best_idx;
        r_best       <= n_best;
        r_best_hash  <= n_best_hash;
        r_out        <= n_out;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    // pending count tracks the valid bits
    `TPD_ASSERT(a_pending_matches, r_pending == CW'($countones(r_svalid)),
                "pending count out of step with slot valid bits")
    // a dispatched task always comes from a valid slot
    `TPD_ASSERT(a_emit_valid,
                (r_state == tptd_pkg::S_EMIT && r_have_best) |-> r_svalid[r_best_idx],
                "dispatch of an empty slot")
    // no result unless a request was just taken or the scan was in emit or finish
    `TPD_ASSERT(a_result_cause, o_valid |-> ($past(accept) ||
                $past(r_state) == tptd_pkg::S_EMIT || $past(r_state) == tptd_pkg::S_FINISH),
                "result without cause")
endmodule
